// ===== hw/rtl/vat_pkg.sv =====
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants for the vector angle block
// Datapath formats, the arctangent table in fractions of a turn, and the
// per-stage payload struct.
// ----------------------------------------------------------------------------
`default_nettype none
package vat_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned ANGLE_WIDTH_DEF = 16;
	localparam int unsigned CORDIC_STEPS    = 32;
	localparam int unsigned TURN_BITS       = 32;
	localparam int unsigned DATA_BITS       = 64;
	localparam int unsigned SCALE_TOP       = 60;

	localparam logic [TURN_BITS-1:0] TURN_ZERO    = 32'h0000_0000;
	localparam logic [TURN_BITS-1:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [TURN_BITS-1:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [TURN_BITS-1:0] TURN_3QUART  = 32'hC000_0000;

	typedef struct packed {
		logic                        special;
		logic signed [DATA_BITS-1:0] x;
		logic signed [DATA_BITS-1:0] y;
		logic [TURN_BITS-1:0]        z;
	} cordic_t;

	function automatic logic [TURN_BITS-1:0] atan_turn(input int unsigned idx);
		logic [TURN_BITS-1:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vat_pre.sv =====
// ----------------------------------------------------------------------------
// vat_pre: input stage
// Sign-extends the coordinates, folds the left half plane by a half turn,
// scales into the wide datapath and flags the axis cases.
// ----------------------------------------------------------------------------
`default_nettype none
module vat_pre #(
	parameter int unsigned COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [COORD_WIDTH-1:0] x_coord,
	input  wire logic [COORD_WIDTH-1:0] y_coord,
	output logic                        out_valid,
	output vat_pkg::cordic_t            out_data
);

	localparam int unsigned DW    = vat_pkg::DATA_BITS;
	localparam int unsigned SHIFT = vat_pkg::SCALE_TOP - COORD_WIDTH;

	logic signed [DW-1:0]           xe;
	logic signed [DW-1:0]           ye;
	logic signed [DW-1:0]           xa;
	logic signed [DW-1:0]           ya;
	logic                           x_neg;
	logic                           x_zero;
	logic                           y_zero;
	logic [vat_pkg::TURN_BITS-1:0]  z0;
	vat_pkg::cordic_t               d;
	logic                           valid_s1;
	vat_pkg::cordic_t               data_s1;

	always_comb begin
		xe     = {{(DW-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord};
		ye     = {{(DW-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord};
		x_neg  = x_coord[COORD_WIDTH-1];
		x_zero = (x_coord == '0);
		y_zero = (y_coord == '0);
		xa     = x_neg ? -xe : xe;
		ya     = x_neg ? -ye : ye;
		if (y_zero) begin
			z0 = x_neg ? vat_pkg::TURN_HALF : vat_pkg::TURN_ZERO;
		end else if (x_zero) begin
			z0 = y_coord[COORD_WIDTH-1] ? vat_pkg::TURN_3QUART : vat_pkg::TURN_QUARTER;
		end else begin
			z0 = x_neg ? vat_pkg::TURN_HALF : vat_pkg::TURN_ZERO;
		end
		d.special = x_zero | y_zero;
		d.x       = xa << SHIFT;
		d.y       = ya << SHIFT;
		d.z       = z0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/vat_stage.sv =====
// ----------------------------------------------------------------------------
// vat_stage: one CORDIC micro-rotation
// Drives y toward zero by a shift-add rotation and steps the turn
// accumulator by this stage's table angle; axis cases pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none
module vat_stage #(
	parameter int unsigned IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  vat_pkg::cordic_t      in_data,
	output logic                  out_valid,
	output vat_pkg::cordic_t      out_data
);

	localparam logic [vat_pkg::TURN_BITS-1:0] ANG = vat_pkg::atan_turn(IDX);

	logic signed [vat_pkg::DATA_BITS-1:0] dx;
	logic signed [vat_pkg::DATA_BITS-1:0] dy;
	vat_pkg::cordic_t                     d;
	logic                                 valid_s1;
	vat_pkg::cordic_t                     data_s1;

	always_comb begin
		dx = in_data.y >>> IDX;
		dy = in_data.x >>> IDX;
		d  = in_data;
		if (!in_data.special) begin
			if (!in_data.y[vat_pkg::DATA_BITS-1]) begin
				d.x = in_data.x + dx;
				d.y = in_data.y - dy;
				d.z = in_data.z + ANG;
			end else begin
				d.x = in_data.x - dx;
				d.y = in_data.y + dy;
				d.z = in_data.z - ANG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/vat_round.sv =====
// ----------------------------------------------------------------------------
// vat_round: output stage
// Rounds the turn accumulator half up to the angle width, wraps, and holds
// the result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module vat_round #(
	parameter int unsigned ANGLE_WIDTH = vat_pkg::ANGLE_WIDTH_DEF,
	parameter int unsigned OUT_BITS    = ((ANGLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [vat_pkg::TURN_BITS-1:0] z,
	output logic                               out_valid,
	output logic [OUT_BITS-1:0]                out_data
);

	localparam int unsigned TB = vat_pkg::TURN_BITS;

	logic [ANGLE_WIDTH-1:0] angle;
	logic                   valid_s1;
	logic [OUT_BITS-1:0]    data_s1;

	generate
		if (ANGLE_WIDTH >= TB) begin : g_full
			assign angle = z[ANGLE_WIDTH-1:0];
		end else begin : g_round
			localparam int unsigned SH = TB - ANGLE_WIDTH;
			logic [TB-1:0] sum;
			assign sum   = z + (TB'(1) << (SH - 1));
			assign angle = sum[TB-1:SH];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= OUT_BITS'(angle);
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/vector_angle_full_turn_top.sv =====
// ----------------------------------------------------------------------------
// vector_angle_full_turn_top: polar angle of a 2-D vector in fractions of a turn
// Pipeline: one input stage, 32 micro-rotation stages, one rounding stage.
// Throughput: one item per cycle; a stall at the output freezes all stages.
// Reset: arst_n clears every stage valid bit at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_angle_full_turn_top #(
	parameter int unsigned COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
	parameter int unsigned ANGLE_WIDTH = vat_pkg::ANGLE_WIDTH_DEF,
	parameter int unsigned IN_BITS     = ((2 * COORD_WIDTH + 7) / 8) * 8,
	parameter int unsigned OUT_BITS    = ((ANGLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IN_BITS-1:0]  s_tdata,  // x_coord, y_coord, zero pad
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_BITS-1:0]      m_tdata   // turn_angle, zero pad
);

	localparam int unsigned N = vat_pkg::CORDIC_STEPS;

	logic             adv;
	logic             vld [0:N];
	vat_pkg::cordic_t stg [0:N];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	vat_pre #(.COORD_WIDTH(COORD_WIDTH)) u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.x_coord   (s_tdata[COORD_WIDTH-1:0]),
		.y_coord   (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.out_valid (vld[0]),
		.out_data  (stg[0])
	);

	generate
		for (genvar k = 0; k < N; k++) begin : g_rot
			vat_stage #(.IDX(k)) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (adv),
				.in_valid  (vld[k]),
				.in_data   (stg[k]),
				.out_valid (vld[k+1]),
				.out_data  (stg[k+1])
			);
		end
	endgenerate

	vat_round #(.ANGLE_WIDTH(ANGLE_WIDTH), .OUT_BITS(OUT_BITS)) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld[N]),
		.z         (stg[N].z),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/vat_checker.sv =====
// ----------------------------------------------------------------------------
// vat_checker: port-level checks for the vector angle block
// Output hold under stall, pipeline flow control and reset state.
// ----------------------------------------------------------------------------
`default_nettype none
module vat_checker #(
	parameter int unsigned OUT_BITS = 16
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OUT_BITS-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with empty output register");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline frozen");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result item shown during reset");

endmodule

bind vector_angle_full_turn_top vat_checker #(.OUT_BITS(OUT_BITS)) u_vat_checker (.*);
`default_nettype wire

// ===== tb/sv/angle_check_pkg.sv =====
// ----------------------------------------------------------------------------
// angle_check_pkg: angle predictor and result scoreboard
// Bit-exact CORDIC vectoring predictor for the polar angle of a 2-D vector,
// expressed in fractions of a full turn, plus a queue of expected angles
// that each result leaving the block is matched against in order.
// ----------------------------------------------------------------------------
package angle_check_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COORD_W   = vat_pkg::COORD_WIDTH_DEF;
	localparam int unsigned ANGLE_W   = vat_pkg::ANGLE_WIDTH_DEF;
	localparam int unsigned TURN_W    = vat_pkg::TURN_BITS;
	localparam int unsigned ROT_STEPS = vat_pkg::CORDIC_STEPS;
	localparam int unsigned PRE_SHIFT = vat_pkg::SCALE_TOP - COORD_W;

	localparam logic [31:0] ATAN_STEP_TURN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	class angle_scoreboard;
		logic [ANGLE_W-1:0] expected_angles[$];
		int unsigned        mismatches;
		int unsigned        vectors_seen;
		int unsigned        angles_checked;

		function new();
			mismatches     = 0;
			vectors_seen   = 0;
			angles_checked = 0;
		endfunction

		function logic [ANGLE_W-1:0] predict_angle(logic signed [COORD_W-1:0] xc,
				logic signed [COORD_W-1:0] yc);
			longint          px;
			longint          py;
			longint          dx;
			longint          dy;
			logic [TURN_W-1:0] acc;
			logic [TURN_W:0]   rnd;
			px  = xc;
			py  = yc;
			acc = vat_pkg::TURN_ZERO;
			if (yc == 0) begin
				acc = (xc < 0) ? vat_pkg::TURN_HALF : vat_pkg::TURN_ZERO;
			end else if (xc == 0) begin
				acc = (yc > 0) ? vat_pkg::TURN_QUARTER : vat_pkg::TURN_3QUART;
			end else begin
				if (px < 0) begin
					px  = -px;
					py  = -py;
					acc = vat_pkg::TURN_HALF;
				end
				px = px <<< PRE_SHIFT;
				py = py <<< PRE_SHIFT;
				for (int i = 0; i < ROT_STEPS; i++) begin
					dx = py >>> i;
					dy = px >>> i;
					if (py >= 0) begin
						px  = px + dx;
						py  = py - dy;
						acc = acc + ATAN_STEP_TURN[i];
					end else begin
						px  = px - dx;
						py  = py + dy;
						acc = acc - ATAN_STEP_TURN[i];
					end
				end
			end
			rnd = {1'b0, acc} + ((TURN_W+1)'(1) << (TURN_W - ANGLE_W - 1));
			return rnd[TURN_W-1 -: ANGLE_W];
		endfunction

		function void note_vector(logic signed [COORD_W-1:0] xc,
				logic signed [COORD_W-1:0] yc);
			expected_angles.push_back(predict_angle(xc, yc));
			vectors_seen++;
		endfunction

		function void check_angle(logic [ANGLE_W-1:0] actual);
			logic [ANGLE_W-1:0] want;
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected turn_angle: expected none, actual %0h",
					$time, actual);
				mismatches++;
				return;
			end
			want = expected_angles.pop_front();
			angles_checked++;
			if (actual !== want) begin
				$display("%0t: turn_angle mismatch: expected %0h, actual %0h",
					$time, want, actual);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_angles.size();
		endfunction

		function void drain_check();
			if (expected_angles.size() != 0) begin
				$display("%0t: %0d turn_angle results missing: expected %0h, actual none",
					$time, expected_angles.size(), expected_angles[0]);
				mismatches += expected_angles.size();
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: vector angle block, full-turn polar angle
// Streams directed and random vectors into the block, predicts each angle
// with a bit-exact CORDIC model and matches every result in order, with
// random idling on both stream sides in the busy phase and a drain pause mid-run.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COORD_W = angle_check_pkg::COORD_W;
	localparam int unsigned ANGLE_W = angle_check_pkg::ANGLE_W;
	localparam int unsigned IN_W    = ((2 * COORD_W + 7) / 8) * 8;
	localparam int unsigned OUT_W   = ((ANGLE_W + 7) / 8) * 8;
	localparam int unsigned N_DIR   = 23;
	localparam int unsigned N_BUSY  = 1100;
	localparam int unsigned N_CALM  = 400;
	localparam int unsigned TAIL_CYC = 40;

	localparam logic signed [COORD_W-1:0] DIR_X [N_DIR] = '{
		0, 1, -1, 32767, -32768, 0, 0, 0, 0, 1, -1, -1,
		1, 32767, -32768, 32767, -32768, 32767, 30000, -32768, -32768, 5, -7
	};
	localparam logic signed [COORD_W-1:0] DIR_Y [N_DIR] = '{
		0, 0, 0, 0, 0, 1, -1, 32767, -32768, 1, 1, -1,
		-1, 32767, -32768, -32768, 32767, -1, -1, -1, 1, -3, 2
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b1;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;  // x_coord, y_coord
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // turn_angle

	bit               src_idle_en = 1'b1;
	bit               sink_stall_en = 1'b1;
	int unsigned      stall_left = 0;
	angle_check_pkg::angle_scoreboard sb;

	vector_angle_full_turn_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_vector(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W]);
			if (m_tvalid && m_tready)
				sb.check_angle(m_tdata[ANGLE_W-1:0]);
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (sink_stall_en && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 6);
		end
	end

	task automatic send_vector(input logic signed [COORD_W-1:0] xc,
			input logic signed [COORD_W-1:0] yc);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_W'($urandom);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({yc, xc});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pick_vector(output logic signed [COORD_W-1:0] xc,
			output logic signed [COORD_W-1:0] yc);
		logic signed [COORD_W-1:0] edge_vals [6];
		logic signed [COORD_W-1:0] mag;
		edge_vals = '{-32768, -32767, -1, 0, 1, 32767};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				xc = COORD_W'($urandom);
				yc = COORD_W'($urandom);
			end
			4: begin
				xc = COORD_W'(int'($urandom_range(0, 16)) - 8);
				yc = COORD_W'(int'($urandom_range(0, 16)) - 8);
			end
			5: begin
				xc = COORD_W'($urandom);
				yc = '0;
				if ($urandom_range(0, 1)) begin
					yc = xc;
					xc = '0;
				end
			end
			6: begin
				xc = COORD_W'($urandom_range(1, 32767));
				yc = COORD_W'(0 - int'($urandom_range(1, 4)));
			end
			7: begin
				xc = edge_vals[$urandom_range(0, 5)];
				yc = edge_vals[$urandom_range(0, 5)];
			end
			8: begin
				mag = COORD_W'($urandom_range(1, 32767));
				xc  = $urandom_range(0, 1) ? -mag : mag;
				yc  = $urandom_range(0, 1) ? -mag : mag;
			end
			default: begin
				xc = COORD_W'(int'($urandom_range(0, 510)) - 255);
				yc = COORD_W'(int'($urandom_range(0, 510)) - 255);
			end
		endcase
	endtask

	initial begin
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		arst_n <= 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_vector(DIR_X[i], DIR_Y[i]);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		for (int i = 0; i < N_BUSY; i++) begin
			pick_vector(vx, vy);
			send_vector(vx, vy);
		end
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		for (int i = 0; i < N_CALM; i++) begin
			pick_vector(vx, vy);
			send_vector(vx, vy);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		sb.drain_check();

		$display("Run covered %0d vectors: zero vector, both axes, diagonals, extremes,",
			sb.vectors_seen);
		$display("near-full-turn wrap and random quadrants; %0d angles checked.",
			sb.angles_checked);
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
